// ===== rtl/core/ffba_pkg.sv =====
`default_nettype none

package ffba_pkg;

    // Fixed field widths of the request and response transactions
    localparam int FUNC_W   = 2;
    localparam int OWNER_W  = 16;
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 2;
    localparam int UNITS_W  = 11;
    localparam int CNT_W    = 5;

    // Request kinds
    localparam logic [FUNC_W-1:0] FUNC_REINIT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd2;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_OWNER = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [UNITS_W-1:0]  used_units;
        logic [CNT_W-1:0]    used_blocks;
        logic [CNT_W-1:0]    free_blocks;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffba_ram.sv =====
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ffba_ctrl.sv =====
`default_nettype none

module ffba_ctrl #(
    parameter int MAX_BLOCKS  = 16,
    parameter int TOTAL_UNITS = 1024,
    localparam int LW      = $clog2(TOTAL_UNITS + 1),
    localparam int IW      = $clog2(MAX_BLOCKS),
    localparam int ENTRY_W = 2 * LW + 1 + ffba_pkg::OWNER_W
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request side
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire logic [ffba_pkg::FUNC_W-1:0]    func,
    input  wire logic [ffba_pkg::OWNER_W-1:0]   owner_id,
    input  wire logic [ffba_pkg::SIZE_W-1:0]    request_size,
    // finished result toward the output register
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output ffba_pkg::rsp_t                      res,
    // table memory
    output logic                                ram_we,
    output logic [IW-1:0]                       ram_waddr,
    output logic [ENTRY_W-1:0]                  ram_wdata,
    output logic                                ram_re,
    output logic [IW-1:0]                       ram_raddr,
    input  wire logic [ENTRY_W-1:0]             ram_rdata
);

    import ffba_pkg::*;

    localparam int CNW   = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (LW > SIZE_W) ? LW : SIZE_W;
    localparam int UXW   = (LW > UNITS_W) ? LW : UNITS_W;
    localparam int CXW   = (CNW > CNT_W) ? CNW : CNT_W;

    typedef struct packed {
        logic [LW-1:0]      start;
        logic [LW-1:0]      len;
        logic               used;
        logic [OWNER_W-1:0] owner;
    } entry_t;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A_RD  = 4'd2;
    localparam logic [3:0] S_A_CHK = 4'd3;
    localparam logic [3:0] S_U_RD  = 4'd4;
    localparam logic [3:0] S_U_WR  = 4'd5;
    localparam logic [3:0] S_F_RD  = 4'd6;
    localparam logic [3:0] S_F_CHK = 4'd7;
    localparam logic [3:0] S_M_LD  = 4'd8;
    localparam logic [3:0] S_M_LDW = 4'd9;
    localparam logic [3:0] S_M_NX  = 4'd10;
    localparam logic [3:0] S_M_CMP = 4'd11;
    localparam logic [3:0] S_D_RD  = 4'd12;
    localparam logic [3:0] S_D_WR  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    localparam logic [CNW-1:0] CNT_ONE = CNW'(1);
    localparam logic [LW-1:0]  TOTAL   = LW'(TOTAL_UNITS);

    logic [3:0]          state_reg, state_next;
    logic [CNW-1:0]      count_reg, count_next;
    logic [CNW-1:0]      used_n_reg, used_n_next;
    logic [LW-1:0]       used_units_reg, used_units_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [OWNER_W-1:0]  owner_reg, owner_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [CNW-1:0]      i_reg, i_next;
    logic [CNW-1:0]      j_reg, j_next;
    entry_t              cur_reg, cur_next;

    entry_t          rd_entry;
    entry_t          wr_entry;
    entry_t          init_entry;
    logic [CNW:0]    i_plus1;
    logic [CNW:0]    j_plus1;
    logic [CMP_W-1:0] size_ext;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] start_ext;
    logic [UXW-1:0]  uu_ext;
    logic [CXW-1:0]  un_ext;
    logic [CXW-1:0]  fn_ext;

    assign rd_entry   = entry_t'(ram_rdata);
    assign ram_wdata  = ENTRY_W'(wr_entry);
    assign init_entry = '{start: '0, len: TOTAL, used: 1'b0, owner: '0};
    assign i_plus1    = {1'b0, i_reg} + (CNW + 1)'(1);
    assign j_plus1    = {1'b0, j_reg} + (CNW + 1)'(1);
    assign size_ext   = CMP_W'(size_reg);
    assign len_ext    = CMP_W'(rd_entry.len);
    assign start_ext  = CMP_W'(rd_entry.start);

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    // counts are kept incrementally; free blocks = entries - used
    assign uu_ext = UXW'(used_units_reg);
    assign un_ext = CXW'(used_n_reg);
    assign fn_ext = CXW'(count_reg - used_n_reg);
    assign res.status      = status_reg;
    assign res.used_units  = uu_ext[UNITS_W-1:0];
    assign res.used_blocks = un_ext[CNT_W-1:0];
    assign res.free_blocks = fn_ext[CNT_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        used_n_next     = used_n_reg;
        used_units_next = used_units_reg;
        status_next     = status_reg;
        owner_next      = owner_reg;
        size_next       = size_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cur_next        = cur_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        wr_entry        = init_entry;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        case (state_reg)
            S_INIT:
            begin
                // one write puts the reset table in place
                ram_we     = 1'b1;
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    owner_next  = owner_id;
                    size_next   = request_size;
                    i_next      = '0;
                    status_next = ST_DONE;
                    case (func)
                        FUNC_REINIT:
                        begin
                            ram_we          = 1'b1;
                            count_next      = CNT_ONE;
                            used_n_next     = '0;
                            used_units_next = '0;
                            state_next      = S_DONE;
                        end
                        FUNC_ALLOC: state_next = S_A_RD;
                        FUNC_FREE:  state_next = S_F_RD;
                        default:    state_next = S_DONE;
                    endcase
                end
            end

            // first-fit scan
            S_A_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    status_next = ST_NO_FIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = i_reg[IW-1:0];
                    state_next = S_A_CHK;
                end
            end

            S_A_CHK:
            begin
                if (!rd_entry.used && (len_ext >= size_ext))
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = i_reg[IW-1:0];
                    wr_entry.start  = rd_entry.start;
                    wr_entry.len    = LW'(size_ext);
                    wr_entry.used   = 1'b1;
                    wr_entry.owner  = owner_reg;
                    used_n_next     = used_n_reg + CNT_ONE;
                    used_units_next = LW'(CMP_W'(used_units_reg) + size_ext);
                    // remainder entry, inserted after the shift
                    cur_next.start  = LW'(start_ext + size_ext);
                    cur_next.len    = LW'(len_ext - size_ext);
                    cur_next.used   = 1'b0;
                    cur_next.owner  = '0;
                    j_next          = count_reg;
                    if ((len_ext != size_ext) && (count_reg < CNW'(MAX_BLOCKS)))
                    begin
                        state_next = S_U_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    i_next     = i_plus1[CNW-1:0];
                    state_next = S_A_RD;
                end
            end

            // open a hole at i+1, top entry first
            S_U_RD:
            begin
                if ({1'b0, j_reg} > i_plus1)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = IW'(j_reg - CNT_ONE);
                    state_next = S_U_WR;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = i_plus1[IW-1:0];
                    wr_entry   = cur_reg;
                    count_next = count_reg + CNT_ONE;
                    state_next = S_DONE;
                end
            end

            S_U_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg[IW-1:0];
                wr_entry   = rd_entry;
                j_next     = j_reg - CNT_ONE;
                state_next = S_U_RD;
            end

            // owner search
            S_F_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    status_next = ST_NO_OWNER;
                    state_next  = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = i_reg[IW-1:0];
                    state_next = S_F_CHK;
                end
            end

            S_F_CHK:
            begin
                if (rd_entry.used && (rd_entry.owner == owner_reg))
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = i_reg[IW-1:0];
                    wr_entry.start  = rd_entry.start;
                    wr_entry.len    = rd_entry.len;
                    wr_entry.used   = 1'b0;
                    wr_entry.owner  = '0;
                    used_n_next     = used_n_reg - CNT_ONE;
                    used_units_next = used_units_reg - rd_entry.len;
                    i_next          = '0;
                    state_next      = S_M_LD;
                end
                else
                begin
                    i_next     = i_plus1[CNW-1:0];
                    state_next = S_F_RD;
                end
            end

            // coalesce pass; cur_reg caches entry i
            S_M_LD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = S_M_LDW;
            end

            S_M_LDW:
            begin
                cur_next   = rd_entry;
                state_next = S_M_NX;
            end

            S_M_NX:
            begin
                if (i_plus1 >= {1'b0, count_reg})
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = i_plus1[IW-1:0];
                    state_next = S_M_CMP;
                end
            end

            S_M_CMP:
            begin
                if (!cur_reg.used && !rd_entry.used)
                begin
                    cur_next.len = cur_reg.len + rd_entry.len;
                    ram_we       = 1'b1;
                    ram_waddr    = i_reg[IW-1:0];
                    wr_entry     = cur_next;
                    j_next       = i_plus1[CNW-1:0];
                    state_next   = S_D_RD;
                end
                else
                begin
                    cur_next   = rd_entry;
                    i_next     = i_plus1[CNW-1:0];
                    state_next = S_M_NX;
                end
            end

            // close the gap left by the merged entry
            S_D_RD:
            begin
                if (j_plus1 < {1'b0, count_reg})
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = j_plus1[IW-1:0];
                    state_next = S_D_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_ONE;
                    state_next = S_M_NX;
                end
            end

            S_D_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg[IW-1:0];
                wr_entry   = rd_entry;
                j_next     = j_plus1[CNW-1:0];
                state_next = S_D_RD;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            count_reg      <= CNT_ONE;
            used_n_reg     <= '0;
            used_units_reg <= '0;
            status_reg     <= ST_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            used_n_reg     <= used_n_next;
            used_units_reg <= used_units_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg <= owner_next;
        size_reg  <= size_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        cur_reg   <= cur_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_ONE) && (count_reg <= CNW'(MAX_BLOCKS)))
        else $error("entry count out of range");

    a_used_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        used_n_reg <= count_reg)
        else $error("more used entries than entries");

    a_units_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        used_units_reg <= TOTAL)
        else $error("used units exceed memory size");

    a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("read and write of one entry in the same cycle");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("finished result lost before the output register took it");

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_block_allocator.sv =====
// Sequence: reinitialize and the unused kind go straight to the response; a scan reads
//   table entries one by one, and a split or a merge then moves entries one at a time,
//   each through the registered read port of the table memory.
// Throughput: one request transaction at a time; the next is taken while the previous
//   response waits in the output register.
// Reset: asynchronous, active low; the S_INIT state after reset writes the initial free block.
`default_nettype none

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS  = 16,
    parameter int TOTAL_UNITS = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic [ffba_pkg::FUNC_W-1:0]     func,
    input  wire logic [ffba_pkg::OWNER_W-1:0]    owner_id,
    input  wire logic [ffba_pkg::SIZE_W-1:0]     request_size,
    // response channel
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output logic [ffba_pkg::STATUS_W-1:0]        status,
    output logic [ffba_pkg::UNITS_W-1:0]         used_units,
    output logic [ffba_pkg::CNT_W-1:0]           used_blocks,
    output logic [ffba_pkg::CNT_W-1:0]           free_blocks
);

    import ffba_pkg::*;

    // Table entry: start, length, used flag and owner, held in one memory
    localparam int LW      = $clog2(TOTAL_UNITS + 1);
    localparam int IW      = $clog2(MAX_BLOCKS);
    localparam int ENTRY_W = 2 * LW + 1 + OWNER_W;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic   res_valid;
    logic   res_ready;
    rsp_t   res;

    // Output register: loads when empty or when its transaction completes
    logic   rsp_valid_reg, rsp_valid_next;
    rsp_t   rsp_reg, rsp_next;

    ffba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: scans, splits, shifts and coalesces entries in the table memory
    ffba_ctrl #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .TOTAL_UNITS (TOTAL_UNITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .owner_id     (owner_id),
        .request_size (request_size),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_ready)
        begin
            rsp_valid_next = res_valid;
            if (res_valid)
            begin
                rsp_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_reg.status;
    assign used_units  = rsp_reg.used_units;
    assign used_blocks = rsp_reg.used_blocks;
    assign free_blocks = rsp_reg.free_blocks;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import ffba_pkg::*;

    localparam int MAX_BLOCKS    = 16;
    localparam int TOTAL_UNITS   = 1024;
    localparam int RANDOM_ITEMS  = 850;
    localparam int DRAIN_CYCLES  = 120;     // idle clocks after the last response, before the verdict
    localparam int CYCLE_LIMIT   = 400000;  // watchdog bound for all 875 transactions, with margin

    // func 3 has no name in the package; the block must treat it as a no-op
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam rsp_t              NO_RSP      = '0;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    logic                req_valid    = 1'b0;
    logic                req_stall;
    logic [FUNC_W-1:0]   func         = FUNC_REINIT;
    logic [OWNER_W-1:0]  owner_id     = '0;
    logic [SIZE_W-1:0]   request_size = '0;
    logic                rsp_valid;
    logic                rsp_stall    = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [UNITS_W-1:0]  used_units;
    logic [CNT_W-1:0]    used_blocks;
    logic [CNT_W-1:0]    free_blocks;

    first_fit_block_allocator #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .TOTAL_UNITS (TOTAL_UNITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .owner_id     (owner_id),
        .request_size (request_size),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .used_units   (used_units),
        .used_blocks  (used_blocks),
        .free_blocks  (free_blocks)
    );

    // ------------------------------------------------------------------
    // Shadow block table. Mirrors the allocator state transaction by
    // transaction; entries at or beyond blk_count are don't-care.
    // ------------------------------------------------------------------
    logic [UNITS_W-1:0] blk_start [MAX_BLOCKS];
    logic [UNITS_W-1:0] blk_len   [MAX_BLOCKS];
    bit                 blk_used  [MAX_BLOCKS];
    logic [OWNER_W-1:0] blk_owner [MAX_BLOCKS];
    int                 blk_count;

    rsp_t expected_rsps [$];   // responses still owed by the DUT, oldest first
    int   mismatches = 0;

    function automatic void table_reinit();
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            blk_start[i] = '0;
            blk_len[i]   = '0;
            blk_used[i]  = 1'b0;
            blk_owner[i] = '0;
        end
        blk_len[0] = UNITS_W'(TOTAL_UNITS);
        blk_count  = 1;
    endfunction

    function automatic void move_entry(int dst, int src);
        blk_start[dst] = blk_start[src];
        blk_len[dst]   = blk_len[src];
        blk_used[dst]  = blk_used[src];
        blk_owner[dst] = blk_owner[src];
    endfunction

    // First fit: trim the hit to size; the tail becomes a new free entry
    // right after it, unless the table is already full (tail is lost).
    function automatic logic [STATUS_W-1:0] table_allocate(logic [OWNER_W-1:0] who,
                                                           logic [SIZE_W-1:0]  units);
        logic [UNITS_W-1:0] rest;
        for (int i = 0; i < blk_count; i++)
        begin
            if (!blk_used[i] && blk_len[i] >= units)
            begin
                rest         = blk_len[i] - units;
                blk_used[i]  = 1'b1;
                blk_owner[i] = who;
                blk_len[i]   = units;
                if (rest != 0 && blk_count < MAX_BLOCKS)
                begin
                    for (int j = blk_count; j > i + 1; j--)
                        move_entry(j, j - 1);
                    blk_start[i + 1] = blk_start[i] + units;
                    blk_len[i + 1]   = rest;
                    blk_used[i + 1]  = 1'b0;
                    blk_owner[i + 1] = '0;
                    blk_count++;
                end
                return ST_DONE;
            end
        end
        return ST_NO_FIT;
    endfunction

    // Release the first block of the owner, then merge every free pair.
    function automatic logic [STATUS_W-1:0] table_release(logic [OWNER_W-1:0] who);
        int k;
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_used[i] && blk_owner[i] == who)
            begin
                blk_used[i]  = 1'b0;
                blk_owner[i] = '0;
                k = 0;
                while (k + 1 < blk_count)
                begin
                    if (!blk_used[k] && !blk_used[k + 1])
                    begin
                        blk_len[k] = blk_len[k] + blk_len[k + 1];
                        for (int j = k + 1; j + 1 < blk_count; j++)
                            move_entry(j, j + 1);
                        blk_count--;
                    end
                    else
                        k++;
                end
                return ST_DONE;
            end
        end
        return ST_NO_OWNER;
    endfunction

    function automatic rsp_t predict_response(logic [FUNC_W-1:0]  kind,
                                              logic [OWNER_W-1:0] who,
                                              logic [SIZE_W-1:0]  units);
        rsp_t r;
        r = '0;
        r.status = ST_DONE;
        case (kind)
            FUNC_REINIT: table_reinit();
            FUNC_ALLOC:  r.status = table_allocate(who, units);
            FUNC_FREE:   r.status = table_release(who);
            default:     ;
        endcase
        // totals after the request; used_units wraps at its width
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_used[i])
            begin
                r.used_units  = r.used_units + blk_len[i];
                r.used_blocks = r.used_blocks + 1'b1;
            end
            else
                r.free_blocks = r.free_blocks + 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Each call waits a random gap (none inside a burst),
    // presents one transaction and holds it until accepted. Valid is only
    // lowered when a gap follows, so back-to-back requests keep it high.
    // With hold_until_empty the sender also waits for every response.
    // ------------------------------------------------------------------
    int req_burst_left = 0;

    task automatic send_request(logic [FUNC_W-1:0]  kind,
                                logic [OWNER_W-1:0] who,
                                logic [SIZE_W-1:0]  units,
                                bit                 typed,
                                rsp_t               typed_rsp,
                                bit                 hold_until_empty);
        int   gap;
        rsp_t predicted;
        if (req_burst_left > 0)
        begin
            gap = 0;
            req_burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 31) == 0)
                req_burst_left = $urandom_range(10, 30);
        end
        if (hold_until_empty && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            while (hold_until_empty && expected_rsps.size() != 0)
                @(posedge clk);
        end
        req_valid    <= 1'b1;
        func         <= kind;
        owner_id     <= who;
        request_size <= units;
        do
            @(posedge clk);
        while (req_stall);
        // accepted at this edge: advance the shadow table
        predicted = predict_response(kind, who, units);
        expected_rsps.push_back(typed ? typed_rsp : predicted);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall before each transaction, then take the
    // first valid one and compare it field by field with the oldest entry.
    // ------------------------------------------------------------------
    task automatic check_field(string label, int want, int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    initial
    begin : rsp_sink
        int   hold;
        int   burst_left;
        rsp_t want;
        burst_left = 0;
        // output valid is unknown until reset has been seen by a clock edge
        wait (rst_n);
        forever
        begin
            if (burst_left > 0)
            begin
                hold = 0;
                burst_left--;
            end
            else
            begin
                hold = $urandom_range(0, 8);
                if ($urandom_range(0, 31) == 0)
                    burst_left = $urandom_range(10, 30);
            end
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                $display("%0t: response with none outstanding, actual %0d/%0d/%0d/%0d",
                         $time, status, used_units, used_blocks, free_blocks);
            end
            else
            begin
                want = expected_rsps.pop_front();
                check_field("status",      int'(want.status),      int'(status));
                check_field("used_units",  int'(want.used_units),  int'(used_units));
                check_field("used_blocks", int'(want.used_blocks), int'(used_blocks));
                check_field("free_blocks", int'(want.free_blocks), int'(free_blocks));
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed transactions. Rows flagged typed carry a hand-written
    // response; the others are checked against the shadow table.
    // ------------------------------------------------------------------
    typedef struct {
        logic [FUNC_W-1:0]  kind;
        logic [OWNER_W-1:0] who;
        logic [SIZE_W-1:0]  units;
        bit                 typed;
        rsp_t               rsp;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 25;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // fresh table, then one block taking all memory
        '{FUNC_REINIT, 16'h0000, 11'd0,    1'b1, '{ST_DONE,     11'd0,    5'd0,  5'd1}},
        '{FUNC_ALLOC,  16'hFFFF, 11'd1024, 1'b1, '{ST_DONE,     11'd1024, 5'd1,  5'd0}},
        // nothing left to give; owner 0 holds nothing
        '{FUNC_ALLOC,  16'h0000, 11'd1,    1'b1, '{ST_NO_FIT,   11'd1024, 5'd1,  5'd0}},
        '{FUNC_FREE,   16'h0000, 11'd0,    1'b1, '{ST_NO_OWNER, 11'd1024, 5'd1,  5'd0}},
        '{FUNC_FREE,   16'hFFFF, 11'd0,    1'b1, '{ST_DONE,     11'd0,    5'd0,  5'd1}},
        // zero-size allocate leaves an empty used block ahead of the free one
        '{FUNC_ALLOC,  16'h0000, 11'd0,    1'b1, '{ST_DONE,     11'd0,    5'd1,  5'd1}},
        // size beyond memory, then the unused request kind
        '{FUNC_ALLOC,  16'h1234, 11'd2047, 1'b1, '{ST_NO_FIT,   11'd0,    5'd1,  5'd1}},
        '{FUNC_UNUSED, 16'hAAAA, 11'h555,  1'b1, '{ST_DONE,     11'd0,    5'd1,  5'd1}},
        // fill the table with unit blocks; the last split drops its tail
        '{FUNC_REINIT, 16'h5555, 11'h2AA,  1'b1, '{ST_DONE,     11'd0,    5'd0,  5'd1}},
        '{FUNC_ALLOC,  16'd1,    11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd2,    11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd3,    11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd4,    11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd5,    11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd6,    11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd7,    11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd8,    11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd9,    11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd10,   11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd11,   11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd12,   11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd13,   11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd14,   11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd15,   11'd1,    1'b0, NO_RSP},
        '{FUNC_ALLOC,  16'd16,   11'd1,    1'b1, '{ST_DONE,     11'd16,   5'd16, 5'd0}}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [FUNC_W-1:0]  kind;
        logic [OWNER_W-1:0] who;
        logic [SIZE_W-1:0]  units;
        int                 pick;

        table_reinit();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_request(directed_rows[r].kind, directed_rows[r].who, directed_rows[r].units,
                         directed_rows[r].typed, directed_rows[r].rsp, 1'b0);

        // Random part: mostly allocate/free churn over a small owner pool so
        // frees find their blocks and splits/merges happen; rare reinit keeps
        // dropped tails from starving the table.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                kind = FUNC_REINIT;
            else if (pick < 4)
                kind = FUNC_UNUSED;
            else if (pick < 60)
                kind = FUNC_ALLOC;
            else
                kind = FUNC_FREE;

            if ($urandom_range(0, 15) == 0)
                who = OWNER_W'($urandom_range(0, 65535));
            else
                who = OWNER_W'($urandom_range(0, 7));

            pick = $urandom_range(0, 99);
            if (pick < 3)
                units = '0;
            else if (pick < 6)
                units = SIZE_W'($urandom_range(1025, 2047));
            else if (pick < 15)
                units = SIZE_W'($urandom_range(129, 1024));
            else
                units = SIZE_W'($urandom_range(1, 128));

            // halfway through, let the response queue run dry once
            send_request(kind, who, units, 1'b0, NO_RSP, n == RANDOM_ITEMS / 2);
        end
        req_valid <= 1'b0;

        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d responses outstanding", $time, expected_rsps.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
